// ===== src/hfna_pkg.sv =====
// shared types and constants of the neighbour-average hole fill block
package hfna_pkg;

  localparam int unsigned CH_W       = 16;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned SIDE_CFG_W = 13;
  localparam int unsigned SIDE_RESET = 4096;
  localparam logic [CH_W-1:0] FILL_RESET = 16'h8000;
  localparam int unsigned SUM_W      = CH_W + 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_W      = 20;
  localparam int unsigned DIV_CYC    = DIV_W / DIV_BITS;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned RD_LAST    = 3;

  typedef enum logic {
    REG_SIDE = 1'b0,
    REG_FILL = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_ORIG = 2'd0,
    KIND_AVG  = 2'd1,
    KIND_FILL = 2'd2
  } fill_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_READ,
    ST_DIV,
    ST_WB,
    ST_EMIT
  } hfna_state_e;

  typedef struct packed {
    logic            action;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } hfna_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [1:0]      fill_kind;
    logic            last_pixel;
  } hfna_out_t;

  typedef struct packed {
    logic       take;
    logic       store;
    logic       rd_en;
    logic       acc_en;
    logic [1:0] step;
    logic       div_en;
    logic       div_first;
    logic       wb;
    logic       emit;
  } hfna_cmd_t;

  typedef struct packed {
    logic fin_go;
    logic out_busy;
  } hfna_sts_t;

endpackage

// ===== src/hole_fill_neighbor_average.sv =====
// Hole fill by neighbour average over a square image streamed column by column.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one word per pixel or
// flush item. Output channel (out_valid_o / out_ready_i / out_data_o): one
// finished pixel, emitted side+1 pixel words after it arrived, or drained by a
// flush word. Configuration: cfg_we_i writes cfg_data_i to register cfg_addr_i
// (0 side length, 1 fill value), only while the block is idle: the user must keep
// to this, the block itself does not enforce it. A word that finishes no pixel
// is only taken and stored. A word that finishes a pixel is taken, stored, then
// reads three rows of three of the four column banks (one shared read address,
// registered ram data), runs the 4 bit per cycle divider, is written back and
// loads the output register.
// The output register lets the next word be taken while a result waits; a
// further result waits in the sequencer until the receiver takes the first.
// Reset clears positions, pending count and output valid, restores side 4096,
// capped at MAX_SIDE, fill value 32768; column rams hold no reset, need no clearing
module hole_fill_neighbor_average #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hfna_pkg::hfna_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hfna_pkg::hfna_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_addr_i,
  input  logic [hfna_pkg::CFG_W-1:0] cfg_data_i
);
  import hfna_pkg::*;

  hfna_cmd_t cmd;
  hfna_sts_t sts;

  hfna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hfna_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/hfna_ram.sv =====
// generic single write port ram with registered read
module hfna_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/hfna_ctrl.sv =====
// sequencer for store, neighbour read, divide, write back and emit
module hfna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output hfna_pkg::hfna_cmd_t cmd_o,
  input  hfna_pkg::hfna_sts_t sts_i
);
  import hfna_pkg::*;

  hfna_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_STORE;
      end
      ST_STORE: begin
        state_d = sts_i.fin_go ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (step_q == STEP_W'(RD_LAST)) begin
          state_d = ST_DIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_CYC - 1)) begin
          state_d = ST_WB;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_WB: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    cmd_o.step      = step_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_STORE: cmd_o.store = 1'b1;
      ST_READ: begin
        cmd_o.rd_en  = (step_q != STEP_W'(RD_LAST));
        cmd_o.acc_en = (step_q != '0);
      end
      ST_DIV: begin
        cmd_o.div_en    = 1'b1;
        cmd_o.div_first = (step_q == '0);
      end
      ST_WB:   cmd_o.wb = 1'b1;
      ST_EMIT: cmd_o.emit = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== src/hfna_dp.sv =====
// column stores, position counters, neighbour sums, divider and output word
module hfna_dp #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hfna_pkg::hfna_cmd_t         cmd_i,
  output hfna_pkg::hfna_sts_t         sts_o,
  input  hfna_pkg::hfna_in_t          in_data_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_addr_i,
  input  logic [hfna_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output hfna_pkg::hfna_out_t         out_data_o
);
  import hfna_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIDE);
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW = $clog2(MAX_SIDE + 3);
  localparam logic [13:0] MAX14 = 14'(MAX_SIDE);
  localparam int unsigned SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

  // four banks, so a word two columns ahead never lands in the left column
  function automatic logic [1:0] bank_inc(input logic [1:0] b);
    bank_inc = b + 2'd1;
  endfunction

  logic [SW-1:0]   side_q;
  logic [CH_W-1:0] fill_q;
  hfna_in_t        item_q;
  logic [AW-1:0]   in_row_q, in_col_q, out_row_q, out_col_q;
  logic [1:0]      in_bank_q, w_bank_q;
  logic [PW-1:0]   pend_q;
  logic [SW-1:0]   s_m1;
  logic [13:0]     side_raw;
  logic [SW-1:0]   side_clamped;
  logic            is_pixel;

  assign s_m1     = side_q - 1'b1;
  assign is_pixel = (action_e'(item_q.action) == ACT_PIXEL);
  assign side_raw = {1'b0, cfg_data_i[SIDE_CFG_W-1:0]};

  always_comb begin
    priority if (side_raw < 14'd2) begin
      side_clamped = SW'(2);
    end else if (side_raw > MAX14) begin
      side_clamped = SW'(MAX_SIDE);
    end else begin
      side_clamped = SW'(side_raw);
    end
  end

  assign sts_o.fin_go = is_pixel ? (pend_q >= PW'(side_q) + 1'b1) : (pend_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_data_i;
  end

  // configuration and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= SW'(SIDE_RST);
      fill_q    <= FILL_RESET;
      in_row_q  <= '0;
      in_col_q  <= '0;
      in_bank_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      w_bank_q  <= '0;
      pend_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SIDE: begin
          side_q    <= side_clamped;
          in_row_q  <= '0;
          in_col_q  <= '0;
          in_bank_q <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          w_bank_q  <= '0;
          pend_q    <= '0;
        end
        REG_FILL: fill_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end else begin
      if (cmd_i.store && is_pixel) begin
        pend_q <= pend_q + 1'b1;
        if (SW'(in_row_q) == s_m1) begin
          in_row_q  <= '0;
          in_bank_q <= bank_inc(in_bank_q);
          in_col_q  <= (SW'(in_col_q) == s_m1) ? '0 : in_col_q + 1'b1;
        end else begin
          in_row_q <= in_row_q + 1'b1;
        end
      end
      if (cmd_i.wb) begin
        pend_q <= pend_q - 1'b1;
        if (SW'(out_row_q) == s_m1) begin
          out_row_q <= '0;
          w_bank_q  <= bank_inc(w_bank_q);
          out_col_q <= (SW'(out_col_q) == s_m1) ? '0 : out_col_q + 1'b1;
        end else begin
          out_row_q <= out_row_q + 1'b1;
        end
      end
    end
  end

  // four column banks, roles rotate as columns complete
  logic [1:0]       fin_bank, inc_bank;
  logic [3:0]       ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] rd_data [4];
  logic [PIX_W-1:0] avg_pix;
  logic [PIX_W-1:0] center_q;
  logic             hole;

  assign inc_bank = bank_inc(w_bank_q);
  assign fin_bank = w_bank_q - 2'd1;
  assign hole     = (center_q == '0);
  assign ram_raddr = AW'({1'b0, out_row_q} + (AW + 1)'(cmd_i.step) - 1'b1);

  always_comb begin
    ram_we    = '0;
    ram_waddr = in_row_q;
    ram_wdata = {item_q.blue_in, item_q.green_in, item_q.red_in};
    if (cmd_i.store && is_pixel) begin
      ram_we[in_bank_q] = 1'b1;
    end else if (cmd_i.wb && hole) begin
      ram_we[w_bank_q] = 1'b1;
      ram_waddr        = out_row_q;
      ram_wdata        = avg_pix;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    hfna_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_SIDE)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .raddr_i (ram_raddr),
      .rdata_o (rd_data[b])
    );
  end

  // neighbour accumulation, one row of three columns per step
  logic [PIX_W-1:0] f_pix, w_pix, i_pix;
  logic             row_ok, left_ok, right_ok;
  logic             use_l, use_m, use_r;
  logic [PW:0]      right_d, pend2;
  logic [SUM_W-1:0] sum_q [3];
  logic [SUM_W-1:0] sum_d [3];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign f_pix = rd_data[fin_bank];
  assign w_pix = rd_data[w_bank_q];
  assign i_pix = rd_data[inc_bank];

  assign left_ok  = (out_col_q != '0);
  assign right_ok = (SW'(out_col_q) != s_m1);
  // right column offset is side + row offset, it counts only once arrived
  assign right_d  = (PW + 1)'(side_q) + (PW + 1)'(cmd_i.step);
  assign pend2    = {1'b0, pend_q} + (PW + 1)'(2);

  always_comb begin
    unique case (cmd_i.step)
      2'd1:    row_ok = (out_row_q != '0);
      2'd3:    row_ok = (SW'(out_row_q) != s_m1);
      default: row_ok = 1'b1;
    endcase
    use_l = row_ok && left_ok && (f_pix != '0);
    use_m = row_ok && (w_pix != '0) &&
            ((cmd_i.step == 2'd1) || ((cmd_i.step == 2'd3) && (pend_q > PW'(1))));
    use_r = row_ok && right_ok && (i_pix != '0) && (right_d < pend2);
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = ((cmd_i.step == 2'd1) ? '0 : sum_q[ch])
                + (use_l ? SUM_W'(f_pix[ch*CH_W +: CH_W]) : '0)
                + (use_m ? SUM_W'(w_pix[ch*CH_W +: CH_W]) : '0)
                + (use_r ? SUM_W'(i_pix[ch*CH_W +: CH_W]) : '0);
    end
    cnt_d = ((cmd_i.step == 2'd1) ? '0 : cnt_q)
          + CNT_W'(use_l) + CNT_W'(use_m) + CNT_W'(use_r);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (cmd_i.step == 2'd2) center_q <= w_pix;
    end
  end

  // restoring divide by the count, four quotient bits per cycle
  logic [DIV_W-1:0] quo_q [3];
  logic [DIV_W-1:0] quo_d [3];
  logic [3:0]       rem_q [3];
  logic [3:0]       rem_d [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      quo_d[ch] = cmd_i.div_first ? DIV_W'(sum_q[ch]) : quo_q[ch];
      rem_d[ch] = cmd_i.div_first ? 4'd0 : rem_q[ch];
      for (int i = 0; i < DIV_BITS; i++) begin
        rem_d[ch] = {rem_d[ch][2:0], quo_d[ch][DIV_W-1]};
        quo_d[ch] = {quo_d[ch][DIV_W-2:0], 1'b0};
        if (rem_d[ch] >= cnt_q) begin
          rem_d[ch]    = rem_d[ch] - cnt_q;
          quo_d[ch][0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // result selection and output word
  hfna_out_t res_d, res_q;
  logic      out_valid_q;

  assign avg_pix = (cnt_q == '0) ? '0 :
                   {quo_q[2][CH_W-1:0], quo_q[1][CH_W-1:0], quo_q[0][CH_W-1:0]};

  always_comb begin
    priority if (!hole) begin
      {res_d.blue_out, res_d.green_out, res_d.red_out} = center_q;
      res_d.fill_kind = KIND_ORIG;
    end else if (avg_pix != '0) begin
      {res_d.blue_out, res_d.green_out, res_d.red_out} = avg_pix;
      res_d.fill_kind = KIND_AVG;
    end else begin
      {res_d.blue_out, res_d.green_out, res_d.red_out} = {fill_q, fill_q, fill_q};
      res_d.fill_kind = KIND_FILL;
    end
    res_d.last_pixel = (SW'(out_row_q) == s_m1) && (SW'(out_col_q) == s_m1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) res_q <= res_d;
    if (cmd_i.emit) out_data_o <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

// ===== src/hfna_checker.sv =====
// port level checks for the hole fill block
module hfna_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hfna_pkg::hfna_out_t out_data_o
);
  import hfna_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // one word at a time
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fill_kind != 2'd3)
    else $error("bad fill kind");

  // kept pixels are never holes
  a_orig_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fill_kind == KIND_ORIG |->
      (out_data_o.red_out != '0 || out_data_o.green_out != '0 ||
       out_data_o.blue_out != '0))
    else $error("hole emitted as original");

  // default fill puts one value in every channel
  a_fill_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fill_kind == KIND_FILL |->
      out_data_o.red_out == out_data_o.green_out &&
      out_data_o.green_out == out_data_o.blue_out)
    else $error("fill value differs between channels");

endmodule

bind hole_fill_neighbor_average hfna_checker u_hfna_checker (.*);
